// ===== sv/csi_pkg.sv =====
`timescale 1ns / 1ps

package csi_pkg;

    localparam int SUM_BITS    = 48;
    localparam int SAMPLE_BITS = 8;

    localparam int PROD_BITS = 2 * SAMPLE_BITS;
    localparam int INC_BITS  = PROD_BITS + 1;
    localparam int ADD_BITS  = ((SUM_BITS > INC_BITS) ? SUM_BITS : INC_BITS) + 1;
    localparam int HALF_BITS = (SUM_BITS + 1) / 2;
    localparam int PP_BITS   = 4 * HALF_BITS;
    localparam int RC_BITS   = 2 * SUM_BITS;
    localparam int RHS_BITS  = RC_BITS + 32;
    localparam int B_BITS    = RC_BITS + 17;
    localparam int T_BITS    = RC_BITS + 36;
    localparam int Q_BITS    = 17;
    localparam int K_BITS    = 5;
    localparam int MUL_STEPS = 8;
    localparam int MIDX_BITS = 3;

    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
    localparam logic [K_BITS-1:0]   K_TOP   = K_BITS'(Q_BITS - 1);

    typedef struct packed {
        logic [PROD_BITS-1:0] dot;
        logic [PROD_BITS-1:0] ref_e;
        logic [PROD_BITS-1:0] cand_e;
    } lane_prod_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] dot;
        logic [SUM_BITS-1:0] ref_e;
        logic [SUM_BITS-1:0] cand_e;
        logic                ovf;
    } frame_sums_t;

    typedef struct packed {
        logic [Q_BITS-1:0] similarity;
        logic              degenerate;
        logic              overflowed;
    } result_t;

    typedef enum logic [2:0] {
        S_ACC,
        S_MUL,
        S_MULD,
        S_TRY,
        S_CMP,
        S_DONE
    } fin_state_t;

    // {overflow, saturated sum}
    function automatic logic [SUM_BITS:0] sat_add(input logic [SUM_BITS-1:0] sum,
                                                  input logic [INC_BITS-1:0] inc);
        logic [ADD_BITS-1:0] w;
        w = ADD_BITS'(sum) + ADD_BITS'(inc);
        if (w > ADD_BITS'(SUM_MAX))
            return {1'b1, SUM_MAX};
        return {1'b0, w[SUM_BITS-1:0]};
    endfunction

endpackage

// ===== sv/csi_if.sv =====
`timescale 1ns / 1ps

interface csi_in_if;
    import csi_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] ref_top;
    logic [SAMPLE_BITS-1:0] ref_bottom;
    logic [SAMPLE_BITS-1:0] cand_top;
    logic [SAMPLE_BITS-1:0] cand_bottom;
    logic                   last_pixel;

    modport source (
        output valid, ref_top, ref_bottom, cand_top, cand_bottom, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, ref_top, ref_bottom, cand_top, cand_bottom, last_pixel,
        output ready
    );
endinterface

interface csi_out_if;
    import csi_pkg::*;

    logic              valid;
    logic              ready;
    logic [Q_BITS-1:0] similarity;
    logic              degenerate;
    logic              overflowed;

    modport source (
        output valid, similarity, degenerate, overflowed,
        input  ready
    );
    modport sink (
        input  valid, similarity, degenerate, overflowed,
        output ready
    );
endinterface

// ===== sv/cosine_similarity_image_unit.sv =====
`timescale 1ns / 1ps

// Cosine similarity of a reference and a candidate image, one pixel position
// per transaction on pixels: four samples (top/bottom half of each image)
// and last_pixel. Two product lanes feed a merge stage that keeps saturating
// dot and energy sums; the transaction with last_pixel set closes the frame.
// Pixels inside a frame are taken at one per cycle.
// After the last pixel, ready stays low while the frame is finished: the sums
// are closed, the finisher loads them, the shared multiplier forms 24x24
// partial products for re*ce and d*d, the 17 result bits are found from the
// top, each by an add and then a compare, and the output register is loaded,
// raising results.valid. A zero energy skips the products and search.
// results carries similarity (unsigned Q1.16, 65536 = 1.0), degenerate and overflowed;
// one transaction per frame. The output register holds its transaction while
// the receiver stalls; the next frame is accumulated meanwhile, and only its
// own finish waits for the register to free.
// Reset clears the running sums, their overflow flag and any pending result.
module cosine_similarity_image_unit (
    input  logic     clk,
    input  logic     rst_n,
    csi_in_if.sink   pixels,
    csi_out_if.source results
);
    import csi_pkg::*;

    lane_prod_t  top_p, bot_p;
    frame_sums_t frame;
    result_t     res;
    logic        frame_valid;
    logic        drained;
    logic        idle;
    logic        take;

    assign pixels.ready = idle && drained;
    assign take         = pixels.valid && pixels.ready;

    csi_lane u_lane_top (
        .ref_s  (pixels.ref_top),
        .cand_s (pixels.cand_top),
        .prod   (top_p)
    );

    csi_lane u_lane_bot (
        .ref_s  (pixels.ref_bottom),
        .cand_s (pixels.cand_bottom),
        .prod   (bot_p)
    );

    csi_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .last        (pixels.last_pixel),
        .top_p       (top_p),
        .bot_p       (bot_p),
        .drained     (drained),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    csi_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame),
        .idle        (idle),
        .res_valid   (results.valid),
        .res_ready   (results.ready),
        .res         (res)
    );

    assign results.similarity = res.similarity;
    assign results.degenerate = res.degenerate;
    assign results.overflowed = res.overflowed;
endmodule

// ===== sv/csi_lane.sv =====
`timescale 1ns / 1ps

module csi_lane (
    input  logic [csi_pkg::SAMPLE_BITS-1:0] ref_s,
    input  logic [csi_pkg::SAMPLE_BITS-1:0] cand_s,
    output csi_pkg::lane_prod_t             prod
);
    import csi_pkg::*;

    always_comb
    begin
        prod.dot    = PROD_BITS'(ref_s) * PROD_BITS'(cand_s);
        prod.ref_e  = PROD_BITS'(ref_s) * PROD_BITS'(ref_s);
        prod.cand_e = PROD_BITS'(cand_s) * PROD_BITS'(cand_s);
    end
endmodule

// ===== sv/csi_accum.sv =====
`timescale 1ns / 1ps

module csi_accum (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic                 last,
    input  csi_pkg::lane_prod_t  top_p,
    input  csi_pkg::lane_prod_t  bot_p,
    output logic                 drained,
    output logic                 frame_valid,
    output csi_pkg::frame_sums_t frame
);
    import csi_pkg::*;

    logic                p1_valid_reg, p1_valid_next;
    logic                p1_last_reg, p1_last_next;
    logic [INC_BITS-1:0] inc_dot_reg, inc_dot_next;
    logic [INC_BITS-1:0] inc_ref_reg, inc_ref_next;
    logic [INC_BITS-1:0] inc_cand_reg, inc_cand_next;

    frame_sums_t         sums_reg, sums_next;
    frame_sums_t         frame_reg, frame_next;
    logic                frame_valid_reg, frame_valid_next;

    logic [SUM_BITS:0]   add_dot, add_ref, add_cand;
    frame_sums_t         upd;

    // merge the two lanes
    always_comb
    begin
        p1_valid_next = take;
        p1_last_next  = take & last;
        inc_dot_next  = INC_BITS'(top_p.dot) + INC_BITS'(bot_p.dot);
        inc_ref_next  = INC_BITS'(top_p.ref_e) + INC_BITS'(bot_p.ref_e);
        inc_cand_next = INC_BITS'(top_p.cand_e) + INC_BITS'(bot_p.cand_e);
    end

    always_comb
    begin
        add_dot    = sat_add(sums_reg.dot, inc_dot_reg);
        add_ref    = sat_add(sums_reg.ref_e, inc_ref_reg);
        add_cand   = sat_add(sums_reg.cand_e, inc_cand_reg);
        upd.dot    = add_dot[SUM_BITS-1:0];
        upd.ref_e  = add_ref[SUM_BITS-1:0];
        upd.cand_e = add_cand[SUM_BITS-1:0];
        upd.ovf    = sums_reg.ovf | add_dot[SUM_BITS] | add_ref[SUM_BITS]
                   | add_cand[SUM_BITS];

        sums_next        = sums_reg;
        frame_next       = frame_reg;
        frame_valid_next = 1'b0;
        if (p1_valid_reg)
        begin
            if (p1_last_reg)
            begin
                sums_next        = '0;
                frame_next       = upd;
                frame_valid_next = 1'b1;
            end
            else
            begin
                sums_next = upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg    <= 1'b0;
            p1_last_reg     <= 1'b0;
            sums_reg        <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg    <= p1_valid_next;
            p1_last_reg     <= p1_last_next;
            sums_reg        <= sums_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_dot_reg  <= inc_dot_next;
        inc_ref_reg  <= inc_ref_next;
        inc_cand_reg <= inc_cand_next;
        frame_reg    <= frame_next;
    end

    assign drained     = !p1_last_reg && !frame_valid_reg;
    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;
endmodule

// ===== sv/csi_finish.sv =====
`timescale 1ns / 1ps

module csi_finish (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 frame_valid,
    input  csi_pkg::frame_sums_t frame,
    output logic                 idle,
    output logic                 res_valid,
    input  logic                 res_ready,
    output csi_pkg::result_t     res
);
    import csi_pkg::*;

    fin_state_t              state_reg, state_next;

    logic [SUM_BITS-1:0]     d_reg, d_next;
    logic [SUM_BITS-1:0]     re_reg, re_next;
    logic [SUM_BITS-1:0]     ce_reg, ce_next;
    logic                    ovf_reg, ovf_next;
    logic                    degen_reg, degen_next;

    logic [MIDX_BITS-1:0]    midx_reg, midx_next;
    logic [2*HALF_BITS-1:0]  prod_reg, prod_next;
    logic [MIDX_BITS-1:0]    pidx_reg, pidx_next;
    logic                    pvalid_reg, pvalid_next;
    logic [RC_BITS-1:0]      rc_reg, rc_next;
    logic [RC_BITS-1:0]      dd_reg, dd_next;

    logic [RHS_BITS-1:0]     a_reg, a_next;
    logic [B_BITS-1:0]       b_reg, b_next;
    logic [T_BITS-1:0]       t_reg, t_next;
    logic [Q_BITS-1:0]       q_reg, q_next;
    logic [K_BITS-1:0]       k_reg, k_next;

    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg, out_next;

    logic [2*HALF_BITS-1:0]  op_a, op_b;
    logic [HALF_BITS-1:0]    half_a, half_b;
    logic [PP_BITS-1:0]      pp_term;
    logic [T_BITS-1:0]       rhs_ext;
    logic                    fits;
    logic                    zero_e;
    logic                    out_free;

    assign zero_e   = (frame.ref_e == '0) || (frame.cand_e == '0);
    assign out_free = !out_valid_reg || res_ready;
    assign rhs_ext  = T_BITS'({dd_reg, 32'd0});
    assign fits     = (t_reg <= rhs_ext) && !q_reg[Q_BITS-1];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_ACC:
            begin
                if (frame_valid)
                    state_next = zero_e ? S_DONE : S_MUL;
            end
            S_MUL:
            begin
                if (midx_reg == MIDX_BITS'(MUL_STEPS - 1))
                    state_next = S_MULD;
            end
            S_MULD:
                state_next = S_TRY;
            S_TRY:
                state_next = S_CMP;
            S_CMP:
                state_next = (k_reg == '0) ? S_DONE : S_TRY;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_ACC;
            end
            default:
                state_next = S_ACC;
        endcase
    end

    // partial-product operand select: bit 2 picks re*ce or d*d, bits 1:0 the halves
    always_comb
    begin
        op_a   = midx_reg[2] ? (2*HALF_BITS)'(d_reg) : (2*HALF_BITS)'(re_reg);
        op_b   = midx_reg[2] ? (2*HALF_BITS)'(d_reg) : (2*HALF_BITS)'(ce_reg);
        half_a = midx_reg[1] ? op_a[2*HALF_BITS-1:HALF_BITS] : op_a[HALF_BITS-1:0];
        half_b = midx_reg[0] ? op_b[2*HALF_BITS-1:HALF_BITS] : op_b[HALF_BITS-1:0];
    end

    always_comb
    begin
        case (pidx_reg[1:0])
            2'b00:   pp_term = PP_BITS'(prod_reg);
            2'b01:   pp_term = PP_BITS'(prod_reg) << HALF_BITS;
            2'b10:   pp_term = PP_BITS'(prod_reg) << HALF_BITS;
            default: pp_term = PP_BITS'(prod_reg) << (2 * HALF_BITS);
        endcase
    end

    always_comb
    begin
        d_next         = d_reg;
        re_next        = re_reg;
        ce_next        = ce_reg;
        ovf_next       = ovf_reg;
        degen_next     = degen_reg;
        midx_next      = midx_reg;
        prod_next      = (2*HALF_BITS)'(half_a) * (2*HALF_BITS)'(half_b);
        pidx_next      = midx_reg;
        pvalid_next    = (state_reg == S_MUL);
        rc_next        = rc_reg;
        dd_next        = dd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && res_ready)
            out_valid_next = 1'b0;

        if (pvalid_reg)
        begin
            if (pidx_reg[2])
                dd_next = dd_reg + pp_term[RC_BITS-1:0];
            else
                rc_next = rc_reg + pp_term[RC_BITS-1:0];
        end

        case (state_reg)
            S_ACC:
            begin
                if (frame_valid)
                begin
                    d_next     = frame.dot;
                    re_next    = frame.ref_e;
                    ce_next    = frame.cand_e;
                    ovf_next   = frame.ovf;
                    degen_next = zero_e;
                    midx_next  = '0;
                    rc_next    = '0;
                    dd_next    = '0;
                    a_next     = '0;
                    b_next     = '0;
                    q_next     = '0;
                    k_next     = K_TOP;
                end
            end
            S_MUL:
                midx_next = midx_reg + 1'b1;
            S_TRY:
            begin
                // (q + 2^k)^2 * rc = q^2*rc + 2^(k+1)*q*rc + 2^(2k)*rc
                t_next = T_BITS'(a_reg) + (T_BITS'(b_reg) << (k_reg + 1'b1))
                       + (T_BITS'(rc_reg) << {k_reg, 1'b0});
            end
            S_CMP:
            begin
                if (fits)
                begin
                    a_next        = t_reg[RHS_BITS-1:0];
                    b_next        = b_reg + (B_BITS'(rc_reg) << k_reg);
                    q_next[k_reg] = 1'b1;
                end
                if (k_reg != '0)
                    k_next = k_reg - 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.similarity = degen_reg ? '0 : q_reg;
                    out_next.degenerate = degen_reg;
                    out_next.overflowed = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            midx_reg      <= '0;
            pvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            midx_reg      <= midx_next;
            pvalid_reg    <= pvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        re_reg    <= re_next;
        ce_reg    <= ce_next;
        ovf_reg   <= ovf_next;
        degen_reg <= degen_next;
        prod_reg  <= prod_next;
        pidx_reg  <= pidx_next;
        rc_reg    <= rc_next;
        dd_reg    <= dd_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        t_reg     <= t_next;
        q_reg     <= q_next;
        k_reg     <= k_next;
        out_reg   <= out_next;
    end

    assign idle      = (state_reg == S_ACC);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
endmodule
